/* hdl/pcfd_pkg.sv */
package pcfd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 2;
    localparam int QUO_WIDTH   = VALUE_WIDTH + FRAC_BITS;
    localparam int CNT_WIDTH   = $clog2(QUO_WIDTH);
    localparam int CFG_IDX_W   = 4;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [VALUE_WIDTH-2:0] uvalue_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // operation codes
    localparam logic [1:0] OP_MEAS  = 2'd0;
    localparam logic [1:0] OP_ERR   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_LOW   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_HIGH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU  = 4'd7;

    typedef struct packed {
        logic [1:0] op;
        value_t     target;
        value_t     measured;
        value_t     error_in;
        uvalue_t    time_step;
    } pid_in_t;

    typedef struct packed {
        value_t drive;
        logic   step_rejected;
    } pid_out_t;

    typedef struct packed {
        logic   start;
        value_t a;
        value_t b;
    } mul_req_t;

    typedef struct packed {
        logic    start;
        value_t  num;
        uvalue_t den;
    } div_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_MUL_P,
        S_WAIT_P,
        S_MUL_I,
        S_WAIT_I,
        S_MUL_IT,
        S_WAIT_IT,
        S_DIV_RAW,
        S_WAIT_RAW,
        S_DIV_ALPHA,
        S_WAIT_ALPHA,
        S_MUL_F,
        S_WAIT_F,
        S_MUL_D,
        S_WAIT_D,
        S_FINISH
    } pcfd_state_t;

    function automatic value_t sat_sum(input sum_t x);
        value_t r;
        if (x > sum_t'(VAL_MAX))
            r = VAL_MAX;
        else if (x < sum_t'(VAL_MIN))
            r = VAL_MIN;
        else
            r = x[VALUE_WIDTH-1:0];
        return r;
    endfunction

    function automatic value_t add_sat(input value_t a, input value_t b);
        return sat_sum(sum_t'(a) + sum_t'(b));
    endfunction

    function automatic value_t sub_sat(input value_t a, input value_t b);
        return sat_sum(sum_t'(a) - sum_t'(b));
    endfunction

    // high limit first, then low: crossed limits give the low one
    function automatic value_t clamp(input value_t x, input value_t lo, input value_t hi);
        value_t r;
        r = x;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r;
    endfunction

endpackage

/* hdl/pcfd_mul.sv */
module pcfd_mul
    import pcfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output value_t   res,
    output logic     done
);

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [PROD_WIDTH-1:0] shifted;
    logic                         v1_reg;
    logic                         done_reg;
    value_t                       res_reg;
    value_t                       res_next;

    // arithmetic shift = floor toward minus infinity
    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        if (shifted > PROD_WIDTH'(VAL_MAX))
            res_next = VAL_MAX;
        else if (shifted < PROD_WIDTH'(VAL_MIN))
            res_next = VAL_MIN;
        else
            res_next = shifted[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
            prod_reg <= PROD_WIDTH'(req.a) * PROD_WIDTH'(req.b);
        if (v1_reg)
            res_reg <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

/* hdl/pcfd_div.sv */
module pcfd_div
    import pcfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output value_t   res,
    output logic     done
);

    localparam logic [QUO_WIDTH-1:0] POS_LIM =
        {{(QUO_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [QUO_WIDTH-1:0] NEG_LIM = POS_LIM + 1'b1;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [VALUE_WIDTH-2:0] rem_reg;
    logic [QUO_WIDTH-1:0]   quo_reg;
    logic                   neg_reg;
    uvalue_t                den_reg;

    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] trial;
    logic [VALUE_WIDTH-1:0] diff;
    logic                   ge;
    logic [VALUE_WIDTH-2:0] rem_next;

    always_comb
    begin
        mag      = req.num[VALUE_WIDTH-1] ? (~req.num + 1'b1) : req.num;
        trial    = {rem_reg, quo_reg[QUO_WIDTH-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[VALUE_WIDTH-2:0] : trial[VALUE_WIDTH-2:0];
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(QUO_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            neg_reg <= req.num[VALUE_WIDTH-1];
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_WIDTH-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    // sign and saturate the magnitude
    always_comb
    begin
        if (neg_reg)
            res = (quo_reg > NEG_LIM) ? VAL_MIN : $signed(-quo_reg[VALUE_WIDTH-1:0]);
        else
            res = (quo_reg > POS_LIM) ? VAL_MAX : $signed(quo_reg[VALUE_WIDTH-1:0]);
    end

    assign done = done_reg;

endmodule

/* hdl/pid_controller_filtered_derivative.sv */
// Single-axis PID step, signed Q16.16, derivative low-pass filter and
// anti-windup clamp on the integrator.
//
// Channels: in_* carries one command beat (op, target, measured, error_in,
// time_step); out_* returns one beat (drive, step_rejected) per command;
// cfg_* writes the eight gain/limit registers, always ready, and is to be
// used only while the controller is idle.
//
// Sequencing: one command at a time. A clear, an unused op or a zero time
// step goes from accept through the prepare and finish states to the output
// register. A full update runs a shared multiplier four or five times and a
// shared 48-step restoring divider up to twice: not at all on the first
// sample after a clear, once with the filter off, twice with filter_tau
// nonzero. The divider makes one quotient bit per cycle.
//
// Stall: the result sits in an output register; a new command is accepted
// while it waits. If the next result is done before the old one is taken,
// the sequencer holds in its finish state until the output frees up.
//
// Reset: rst_n is asynchronous, active low. Gains go to zero, clamps to the
// full range, filter off, integrator and history cleared, no output beat.
module pid_controller_filtered_derivative
    import pcfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pid_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pid_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  value_t               cfg_data
);

    // configuration
    value_t  prop_gain_reg;
    value_t  integ_gain_reg;
    value_t  deriv_gain_reg;
    value_t  output_low_reg;
    value_t  output_high_reg;
    value_t  accum_low_reg;
    value_t  accum_high_reg;
    uvalue_t filter_tau_reg;

    // controller state
    value_t  integ_reg;
    value_t  prev_val_reg;
    value_t  prev_der_reg;
    logic    hist_reg;

    // per-command working registers
    pid_in_t  item_reg;
    value_t   err_reg;
    value_t   p_reg;
    value_t   tmp_reg;
    value_t   raw_reg;
    value_t   alpha_reg;
    value_t   deriv_reg;
    pid_out_t result_reg;

    // output stage
    logic     out_valid_reg;
    pid_out_t out_reg;

    pcfd_state_t state_reg;
    pcfd_state_t state_next;

    mul_req_t mul_req;
    value_t   mul_res;
    logic     mul_done;
    div_req_t div_req;
    value_t   div_res;
    logic     div_done;

    logic     is_update;
    logic     dt_zero;
    logic     load_ok;
    value_t   dt_val;
    value_t   sample;
    uvalue_t  tau_dt;
    logic [VALUE_WIDTH-1:0] tau_dt_sum;

    pcfd_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res),
        .done  (mul_done)
    );

    pcfd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res),
        .done  (div_done)
    );

    always_comb
    begin
        is_update  = (item_reg.op == OP_MEAS) || (item_reg.op == OP_ERR);
        dt_zero    = (item_reg.time_step == '0);
        dt_val     = {1'b0, item_reg.time_step};
        sample     = (item_reg.op == OP_MEAS) ? item_reg.measured : item_reg.error_in;
        tau_dt_sum = {1'b0, filter_tau_reg} + {1'b0, item_reg.time_step};
        // saturate tau + dt to the positive range
        tau_dt     = tau_dt_sum[VALUE_WIDTH-1] ? '1 : tau_dt_sum[VALUE_WIDTH-2:0];
        load_ok    = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_PREP;
            S_PREP:       state_next = (is_update && !dt_zero) ? S_MUL_P : S_FINISH;
            S_MUL_P:      state_next = S_WAIT_P;
            S_WAIT_P:     if (mul_done) state_next = S_MUL_I;
            S_MUL_I:      state_next = S_WAIT_I;
            S_WAIT_I:     if (mul_done) state_next = S_MUL_IT;
            S_MUL_IT:     state_next = S_WAIT_IT;
            S_WAIT_IT:    if (mul_done) state_next = hist_reg ? S_DIV_RAW : S_MUL_D;
            S_DIV_RAW:    state_next = S_WAIT_RAW;
            S_WAIT_RAW:
                if (div_done)
                    state_next = (filter_tau_reg != '0) ? S_DIV_ALPHA : S_MUL_D;
            S_DIV_ALPHA:  state_next = S_WAIT_ALPHA;
            S_WAIT_ALPHA: if (div_done) state_next = S_MUL_F;
            S_MUL_F:      state_next = S_WAIT_F;
            S_WAIT_F:     if (mul_done) state_next = S_MUL_D;
            S_MUL_D:      state_next = S_WAIT_D;
            S_WAIT_D:     if (mul_done) state_next = S_FINISH;
            S_FINISH:     if (load_ok) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // unit requests
    always_comb
    begin
        mul_req = '0;
        div_req = '0;
        case (state_reg)
            S_MUL_P:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = prop_gain_reg;
                mul_req.b     = err_reg;
            end
            S_MUL_I:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = integ_gain_reg;
                mul_req.b     = err_reg;
            end
            S_MUL_IT:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = tmp_reg;
                mul_req.b     = dt_val;
            end
            S_DIV_RAW:
            begin
                div_req.start = 1'b1;
                // derivative on measurement uses old - new
                div_req.num   = (item_reg.op == OP_MEAS)
                                ? sub_sat(prev_val_reg, item_reg.measured)
                                : sub_sat(item_reg.error_in, prev_val_reg);
                div_req.den   = item_reg.time_step;
            end
            S_DIV_ALPHA:
            begin
                div_req.start = 1'b1;
                div_req.num   = dt_val;
                div_req.den   = tau_dt;
            end
            S_MUL_F:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = alpha_reg;
                mul_req.b     = sub_sat(raw_reg, prev_der_reg);
            end
            S_MUL_D:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = deriv_gain_reg;
                mul_req.b     = deriv_reg;
            end
            default:
            begin
                mul_req = '0;
                div_req = '0;
            end
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            output_low_reg  <= VAL_MIN;
            output_high_reg <= VAL_MAX;
            accum_low_reg   <= VAL_MIN;
            accum_high_reg  <= VAL_MAX;
            filter_tau_reg  <= '0;
            integ_reg       <= '0;
            prev_val_reg    <= '0;
            prev_der_reg    <= '0;
            hist_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_FINISH && load_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                    REG_OUTPUT_LOW:  output_low_reg  <= cfg_data;
                    REG_OUTPUT_HIGH: output_high_reg <= cfg_data;
                    REG_ACCUM_LOW:   accum_low_reg   <= cfg_data;
                    REG_ACCUM_HIGH:  accum_high_reg  <= cfg_data;
                    REG_FILTER_TAU:  filter_tau_reg  <= cfg_data[VALUE_WIDTH-2:0];
                    default:         ;
                endcase
            end

            if (state_reg == S_PREP && item_reg.op == OP_CLEAR)
            begin
                integ_reg    <= '0;
                prev_val_reg <= '0;
                prev_der_reg <= '0;
                hist_reg     <= 1'b0;
            end

            if (state_reg == S_WAIT_IT && mul_done)
            begin
                integ_reg <= clamp(add_sat(integ_reg, mul_res),
                                   accum_low_reg, accum_high_reg);
                hist_reg  <= 1'b1;
            end

            if (state_reg == S_WAIT_D && mul_done)
            begin
                prev_val_reg <= sample;
                prev_der_reg <= deriv_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;

        case (state_reg)
            S_PREP:
            begin
                err_reg <= (item_reg.op == OP_MEAS)
                           ? sub_sat(item_reg.target, item_reg.measured)
                           : item_reg.error_in;
                result_reg.drive         <= '0;
                result_reg.step_rejected <= is_update && dt_zero;
            end
            S_WAIT_P:
                if (mul_done) p_reg <= mul_res;
            S_WAIT_I:
                if (mul_done) tmp_reg <= mul_res;
            S_WAIT_IT:
                if (mul_done && !hist_reg) deriv_reg <= '0;
            S_WAIT_RAW:
                if (div_done)
                begin
                    raw_reg   <= div_res;
                    deriv_reg <= div_res;
                end
            S_WAIT_ALPHA:
                if (div_done) alpha_reg <= div_res;
            S_WAIT_F:
                if (mul_done) deriv_reg <= add_sat(prev_der_reg, mul_res);
            S_WAIT_D:
                if (mul_done)
                    result_reg.drive <= clamp(
                        sat_sum(sum_t'(p_reg) + sum_t'(integ_reg) + sum_t'(mul_res)),
                        output_low_reg, output_high_reg);
            default: ;
        endcase

        if (state_reg == S_FINISH && load_ok)
            out_reg <= result_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

/* hdl/pcfd_checker.sv */
module pcfd_checker
    import pcfd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input pid_out_t             out_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // one command at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");

    // a new result only comes from a command in progress
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output beat without a command in progress");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared the cycle after accept");

    // a rejected step drives zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.step_rejected |-> out_data.drive == '0)
        else $error("rejected step with nonzero drive");

endmodule

bind pid_controller_filtered_derivative pcfd_checker u_pcfd_checker (.*);

/* bench/pid_drive_checker.sv */
`timescale 1ns / 100ps

// Watches the command, result and register channels of the PID block, keeps
// its own copy of the controller state and compares every result beat.
module pid_drive_checker
    import pcfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  pid_in_t              in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  pid_out_t             out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  value_t               cfg_data,
    output int                   fail_count,
    output int                   waiting
);

    localparam longint Q_MAX = longint'(VAL_MAX);
    localparam longint Q_MIN = longint'(VAL_MIN);

    // register copy
    longint kp, ki, kd;
    longint out_lo, out_hi, acc_lo, acc_hi;
    longint tau;

    // loop state
    longint integ;
    longint last_sample;
    longint last_deriv;
    bit     primed;

    pid_out_t pending_drives[$];
    int       mismatches;

    function automatic longint q_sat(input longint x);
        if (x > Q_MAX)
            return Q_MAX;
        if (x < Q_MIN)
            return Q_MIN;
        return x;
    endfunction

    // arithmetic shift floors, as the block rounds toward minus infinity
    function automatic longint q_mul(input longint a, input longint b);
        return q_sat((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint q_div(input longint a, input longint b);
        return q_sat((a * (longint'(1) <<< FRAC_BITS)) / b);
    endfunction

    function automatic pid_out_t pid_step_drive(input pid_in_t cmd);
        pid_out_t res;
        longint   tgt, meas, e_in, dt;
        longint   err, sample, raw, deriv, alpha, total;
        res    = '0;
        tgt    = longint'($signed(cmd.target));
        meas   = longint'($signed(cmd.measured));
        e_in   = longint'($signed(cmd.error_in));
        dt     = longint'(cmd.time_step);
        if (cmd.op == OP_CLEAR)
        begin
            integ       = 0;
            last_sample = 0;
            last_deriv  = 0;
            primed      = 1'b0;
        end
        else if (cmd.op == OP_NONE)
        begin
            // no effect at all
        end
        else if (dt == 0)
        begin
            res.step_rejected = 1'b1;
        end
        else
        begin
            if (cmd.op == OP_MEAS)
            begin
                err    = q_sat(tgt - meas);
                sample = meas;
            end
            else
            begin
                err    = e_in;
                sample = e_in;
            end
            integ = q_sat(integ + q_mul(q_mul(ki, err), dt));
            if (integ > acc_hi)
                integ = acc_hi;
            if (integ < acc_lo)
                integ = acc_lo;
            deriv = 0;
            if (primed)
            begin
                if (cmd.op == OP_MEAS)
                    raw = q_div(q_sat(last_sample - meas), dt);
                else
                    raw = q_div(q_sat(e_in - last_sample), dt);
                if (tau > 0)
                begin
                    alpha = q_div(dt, q_sat(tau + dt));
                    deriv = q_sat(last_deriv + q_mul(alpha, q_sat(raw - last_deriv)));
                end
                else
                    deriv = raw;
            end
            primed      = 1'b1;
            last_sample = sample;
            last_deriv  = deriv;
            total = q_sat(q_mul(kp, err) + integ + q_mul(kd, deriv));
            if (total > out_hi)
                total = out_hi;
            if (total < out_lo)
                total = out_lo;
            res.drive = value_t'(total);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pid_out_t want;
        if (!rst_n)
        begin
            kp          = 0;
            ki          = 0;
            kd          = 0;
            out_lo      = Q_MIN;
            out_hi      = Q_MAX;
            acc_lo      = Q_MIN;
            acc_hi      = Q_MAX;
            tau         = 0;
            integ       = 0;
            last_sample = 0;
            last_deriv  = 0;
            primed      = 1'b0;
            mismatches  = 0;
            pending_drives.delete();
            fail_count <= 0;
            waiting    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:   kp     = longint'($signed(cfg_data));
                    REG_INTEG_GAIN:  ki     = longint'($signed(cfg_data));
                    REG_DERIV_GAIN:  kd     = longint'($signed(cfg_data));
                    REG_OUTPUT_LOW:  out_lo = longint'($signed(cfg_data));
                    REG_OUTPUT_HIGH: out_hi = longint'($signed(cfg_data));
                    REG_ACCUM_LOW:   acc_lo = longint'($signed(cfg_data));
                    REG_ACCUM_HIGH:  acc_hi = longint'($signed(cfg_data));
                    REG_FILTER_TAU:  tau    = longint'(cfg_data[VALUE_WIDTH-2:0]);
                    default: ;
                endcase
            end
            // a result always belongs to an older command than one taken now
            if (out_valid && out_ready)
            begin
                if (pending_drives.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, got drive %0d rejected %0b",
                             $time, $signed(out_data.drive), out_data.step_rejected);
                end
                else
                begin
                    want = pending_drives.pop_front();
                    if (out_data.drive !== want.drive)
                    begin
                        mismatches++;
                        $display("%0t: drive expected %0d, got %0d",
                                 $time, $signed(want.drive), $signed(out_data.drive));
                    end
                    if (out_data.step_rejected !== want.step_rejected)
                    begin
                        mismatches++;
                        $display("%0t: step_rejected expected %0b, got %0b",
                                 $time, want.step_rejected, out_data.step_rejected);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_drives.push_back(pid_step_drive(in_data));
            fail_count <= mismatches;
            waiting    <= pending_drives.size();
        end
    end

endmodule

/* bench/tb_pid_controller_filtered_derivative.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the filtered-derivative PID block. All result
// checking lives in pid_drive_checker; this module only drives beats and decides.
module tb_pid_controller_filtered_derivative;
    import pcfd_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 108;
    // idle wait long enough to outlast the slowest update (filter on)
    localparam int SETTLE_CYCLES = 130;
    // cycles with no beat on any channel before we give up
    localparam int STUCK_LIMIT   = 5000;

    // indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_FILTER_TAU + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    localparam value_t Q_ONE = 32'sh0001_0000;

    typedef struct {
        value_t  prop_gain;
        value_t  integ_gain;
        value_t  deriv_gain;
        value_t  output_low;
        value_t  output_high;
        value_t  accum_low;
        value_t  accum_high;
        uvalue_t filter_tau;
    } pid_settings_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    pid_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    pid_out_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    value_t               cfg_data  = '0;

    int     fail_count;
    int     waiting;
    int     stuck_cycles = 0;
    // when set, neither side inserts gaps
    bit     quiet = 1'b0;
    // slowly drifting operating point for realistic samples
    value_t level = '0;

    pid_controller_filtered_derivative dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(4, 1);
        if (r < 97)
            return $urandom_range(16, 5);
        return $urandom_range(80, 30);
    endfunction

    function automatic pid_settings_t make_settings(
        input value_t kp, input value_t ki, input value_t kd,
        input value_t olo, input value_t ohi, input value_t alo, input value_t ahi,
        input uvalue_t tau);
        pid_settings_t s;
        s.prop_gain   = kp;
        s.integ_gain  = ki;
        s.deriv_gain  = kd;
        s.output_low  = olo;
        s.output_high = ohi;
        s.accum_low   = alo;
        s.accum_high  = ahi;
        s.filter_tau  = tau;
        return s;
    endfunction

    function automatic pid_in_t make_cmd(input logic [1:0] op, input value_t tgt,
                                         input value_t meas, input value_t err,
                                         input uvalue_t dt);
        pid_in_t c;
        c.op        = op;
        c.target    = tgt;
        c.measured  = meas;
        c.error_in  = err;
        c.time_step = dt;
        return c;
    endfunction

    // Gains: zero, the extremes, full random, or a sane +/-4.0 range.
    function automatic value_t roll_gain();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return VAL_MAX;
            2:       return VAL_MIN;
            3:       return value_t'($urandom);
            default: return value_t'(int'($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000);
        endcase
    endfunction

    // Clamp pairs: full range, raw random (crosses half the time), or a
    // window around zero of up to +/-256.0.
    function automatic void roll_bounds(output value_t lo, output value_t hi);
        case ($urandom_range(4, 0))
            0:
            begin
                lo = VAL_MIN;
                hi = VAL_MAX;
            end
            1:
            begin
                lo = value_t'($urandom);
                hi = value_t'($urandom);
            end
            default:
            begin
                lo = -value_t'($urandom_range(32'h0100_0000, 0));
                hi = value_t'($urandom_range(32'h0100_0000, 0));
            end
        endcase
    endfunction

    function automatic uvalue_t roll_tau();
        case ($urandom_range(5, 0))
            0, 1:    return '0;
            2:       return uvalue_t'($urandom_range(32'h0002_0000, 1));
            3:       return uvalue_t'($urandom);
            4:       return '1;
            default: return uvalue_t'($urandom_range(32'h0000_4000, 1));
        endcase
    endfunction

    function automatic pid_settings_t roll_settings();
        value_t olo, ohi, alo, ahi;
        roll_bounds(olo, ohi);
        roll_bounds(alo, ahi);
        return make_settings(roll_gain(), roll_gain(), roll_gain(),
                             olo, ohi, alo, ahi, roll_tau());
    endfunction

    // Samples sit near the operating point most of the time so the
    // derivative and integrator see smooth signals; the rest is noise.
    function automatic value_t roll_sample();
        case ($urandom_range(9, 0))
            0: return value_t'($urandom);
            1:
            begin
                case ($urandom_range(3, 0))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return -value_t'(1);
                endcase
            end
            default: return level + value_t'(int'($urandom_range(32'h0004_0000, 0))
                                              - 32'sh0002_0000);
        endcase
    endfunction

    // Time steps: mostly millisecond-ish, some tiny, huge or zero (rejects).
    function automatic uvalue_t roll_step();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5)
            return '0;
        if (r < 12)
            return uvalue_t'(1);
        if (r < 20)
            return uvalue_t'($urandom);
        if (r < 24)
            return '1;
        return uvalue_t'($urandom_range(32'h0000_2000, 32'h0000_0040));
    endfunction

    // Clears are rare so that long histories build up.
    function automatic pid_in_t roll_cmd();
        int         r;
        logic [1:0] op;
        r  = $urandom_range(99, 0);
        op = (r < 47) ? OP_MEAS : (r < 94) ? OP_ERR : (r < 98) ? OP_CLEAR : OP_NONE;
        return make_cmd(op, roll_sample(), roll_sample(), roll_sample(), roll_step());
    endfunction

    // Wait until every expected result beat has been taken. The first edge
    // lets the checker count a command accepted at the current edge.
    task automatic wait_settled();
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    // One command beat, optionally after a gap or after a full drain.
    task automatic send_cmd(input pid_in_t cmd, input bit drain);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (drain || gap > 0)
        begin
            in_valid <= 1'b0;
            if (drain)
                wait_settled();
            else
                repeat (gap) @(posedge clk);
        end
        in_data  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Register write beat; cfg_valid stays up for back-to-back writes.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input value_t val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drain, let the sequencer go idle, then rewrite every register plus a
    // write to an unused index. The top bit of the tau write is junk.
    task automatic reconfigure(input pid_settings_t s);
        in_valid <= 1'b0;
        wait_settled();
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(REG_PROP_GAIN, s.prop_gain);
        put_reg(REG_INTEG_GAIN, s.integ_gain);
        put_reg(REG_DERIV_GAIN, s.deriv_gain);
        put_reg(REG_OUTPUT_LOW, s.output_low);
        put_reg(REG_OUTPUT_HIGH, s.output_high);
        put_reg(REG_ACCUM_LOW, s.accum_low);
        put_reg(REG_ACCUM_HIGH, s.accum_high);
        put_reg(REG_FILTER_TAU, {1'($urandom_range(1, 0)), s.filter_tau});
        put_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), value_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure before each beat, none when quiet.
    initial
    begin : result_side
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = quiet ? 0 : idle_len();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : command_side
        uvalue_t ms10;
        ms10 = uvalue_t'(32'h0000_028F);    // ~10 ms

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all gains zero, so drive stays zero.
        send_cmd(make_cmd(OP_MEAS, 3 * Q_ONE, Q_ONE, '0, ms10), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, -2 * Q_ONE, ms10), 1'b0);

        // Moderate gains, bounded clamps, filter on.
        reconfigure(make_settings(Q_ONE, 32'sh0000_8000, 32'sh0002_0000,
                                  -32'sh0064_0000, 32'sh0064_0000,
                                  -32'sh0032_0000, 32'sh0032_0000,
                                  uvalue_t'(32'h0000_4000)));
        send_cmd(make_cmd(OP_CLEAR, value_t'($urandom), value_t'($urandom),
                          value_t'($urandom), uvalue_t'($urandom)), 1'b0);
        // unused op: no effect
        send_cmd(make_cmd(OP_NONE, value_t'($urandom), value_t'($urandom),
                          value_t'($urandom), uvalue_t'($urandom)), 1'b0);
        // zero time step on both update ops is refused
        send_cmd(make_cmd(OP_MEAS, Q_ONE, '0, '0, '0), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, Q_ONE, '0), 1'b0);
        // samples right after a clear; the first two saturate the error both ways
        send_cmd(make_cmd(OP_MEAS, VAL_MAX, VAL_MIN, '0, uvalue_t'(32'h100)), 1'b0);
        send_cmd(make_cmd(OP_MEAS, VAL_MIN, VAL_MAX, '0, uvalue_t'(32'h100)), 1'b0);
        send_cmd(make_cmd(OP_MEAS, '0, '0, '0, '1), 1'b0);
        // tiny time step blows the raw derivative up to the rails
        send_cmd(make_cmd(OP_ERR, '0, '0, VAL_MAX, uvalue_t'(1)), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, VAL_MIN, uvalue_t'(1)), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, Q_ONE, uvalue_t'(32'h1000)), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, -value_t'(1), uvalue_t'(32'h1000)), 1'b0);
        send_cmd(make_cmd(OP_CLEAR, '0, '0, '0, '0), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, 32'sh0000_8000, uvalue_t'(32'h1000)), 1'b0);
        send_cmd(make_cmd(OP_MEAS, 2 * Q_ONE, Q_ONE, '0, uvalue_t'(32'h1000)), 1'b0);

        // Extreme gains, both clamp pairs crossed, longest filter.
        reconfigure(make_settings(VAL_MAX, VAL_MIN, VAL_MAX,
                                  Q_ONE, -Q_ONE, 5 * Q_ONE, '0, '1));
        send_cmd(make_cmd(OP_MEAS, Q_ONE, '0, '0, uvalue_t'(32'h1000)), 1'b0);
        send_cmd(make_cmd(OP_MEAS, -Q_ONE, 3 * Q_ONE, '0, '1), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, VAL_MAX, uvalue_t'(Q_ONE)), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, VAL_MIN, uvalue_t'(1)), 1'b0);
        send_cmd(make_cmd(OP_CLEAR, '0, '0, '0, '0), 1'b0);
        send_cmd(make_cmd(OP_ERR, '0, '0, 32'sh0000_1234, uvalue_t'(32'h10)), 1'b0);
        send_cmd(make_cmd(OP_MEAS, Q_ONE, Q_ONE, '0, '0), 1'b0);

        // Random phases, each with fresh settings; roughly one in four runs
        // without any gaps, and now and then the sender drains mid-phase.
        for (int p = 0; p < PHASES; p++)
        begin
            reconfigure(roll_settings());
            quiet <= ($urandom_range(3, 0) == 0);
            level = value_t'(int'($urandom_range(32'h0200_0000, 0)) - 32'sh0100_0000);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                level = level + value_t'(int'($urandom_range(32'h1000, 0)) - 32'sh0800);
                send_cmd(roll_cmd(), $urandom_range(59, 0) == 0);
            end
        end

        in_valid <= 1'b0;
        wait_settled();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/pcfd_pkg.sv
hdl/pcfd_mul.sv
hdl/pcfd_div.sv
hdl/pid_controller_filtered_derivative.sv
hdl/pcfd_checker.sv
bench/pid_drive_checker.sv
bench/tb_pid_controller_filtered_derivative.sv
